/* sv/bsrch_pkg.sv */
`default_nettype none

package bsrch_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_t;

endpackage

`default_nettype wire

/* sv/bsrch_ram.sv */
`default_nettype none

module bsrch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* sv/bsrch_cmp.sv */
`default_nettype none

module bsrch_cmp
    import bsrch_pkg::*;
(
    input  wire logic signed [DATA_W-1:0] key,
    input  wire logic signed [DATA_W-1:0] probe,
    output cmp_t                          res
);

    // signed (two's complement) compare, shared by every probe
    always_comb
    begin
        res.eq = (key == probe);
        res.lt = (key < probe);
    end

endmodule

`default_nettype wire

/* sv/sorted_table_binary_search.sv */
`default_nettype none

// Sorted table binary search.
// Items go in on start while busy is low. kind = 0 writes entry_value at
// entry_index (ignored when the index is beyond the table) and gives no
// result; busy stays low, so a further item may follow next cycle.
// kind = 1 searches [low_bound, high_bound] for search_key; high_bound
// is clipped to the last entry. busy is high while the search runs.
// Each probe passes S_CHECK, which tests the range and issues the table
// read, then S_CMP, which compares the entry read with the key. There are
// p probes (p <= log2(depth) + 1, five for 16 entries); the result is
// registered as S_CMP hits, or on a miss or empty range as S_CHECK finds lo > hi.
// The result is shown on found/position for the single cycle in which
// done is high; busy is already low then. The receiver cannot stall.
// Reset clears the sequencer, the result strobe and found/position; table contents are
// undefined until written.
module sorted_table_binary_search
    import bsrch_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     kind,
    input  wire logic        [IDX_W-1:0]  entry_index,
    input  wire logic signed [DATA_W-1:0] entry_value,
    input  wire logic signed [DATA_W-1:0] search_key,
    input  wire logic        [IDX_W-1:0]  low_bound,
    input  wire logic        [IDX_W-1:0]  high_bound,
    output logic                          done,
    output logic                          found,
    output logic             [IDX_W-1:0]  position
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int MAX_IDX = TABLE_DEPTH - 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_CMP   = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic signed [IDX_W+1:0]    lo_reg, lo_next;
    logic signed [IDX_W+1:0]    hi_reg, hi_next;
    logic signed [DATA_W-1:0]   key_reg, key_next;
    logic        [IDX_W-1:0]    mid_reg, mid_next;
    logic                       done_reg, done_next;
    logic                       found_reg, found_next;
    logic        [IDX_W-1:0]    position_reg, position_next;

    logic                       accept;
    logic                       ram_we;
    logic        [ADDR_W-1:0]   ram_addr;
    logic signed [DATA_W-1:0]   ram_rdata;
    logic signed [IDX_W+1:0]    hi_init;
    logic        [IDX_W:0]      mid_sum;
    logic        [IDX_W-1:0]    mid_comb;
    cmp_t                       cmp_res;

    assign accept   = start && (state_reg == S_IDLE);
    assign ram_we   = accept && (kind == KIND_WRITE) && (int'(entry_index) < TABLE_DEPTH);
    assign mid_sum  = {1'b0, lo_reg[IDX_W-1:0]} + {1'b0, hi_reg[IDX_W-1:0]};
    assign mid_comb = mid_sum[IDX_W:1];
    assign ram_addr = ram_we ? ADDR_W'(entry_index) : ADDR_W'(mid_comb);
    assign hi_init  = (int'(high_bound) > MAX_IDX) ? (IDX_W+2)'(MAX_IDX)
                                                   : {2'b00, high_bound};

    bsrch_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (entry_value),
        .rdata (ram_rdata)
    );

    bsrch_cmp u_cmp (
        .key   (key_reg),
        .probe (ram_rdata),
        .res   (cmp_res)
    );

    always_comb
    begin
        state_next    = state_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        key_next      = key_reg;
        mid_next      = mid_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        position_next = position_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (kind == KIND_SEARCH))
                begin
                    lo_next    = {2'b00, low_bound};
                    hi_next    = hi_init;
                    key_next   = search_key;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (lo_reg > hi_reg)
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b0;
                    position_next = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    mid_next   = mid_comb;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (cmp_res.eq)
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b1;
                    position_next = mid_reg;
                    state_next    = S_IDLE;
                end
                else
                begin
                    if (cmp_res.lt)
                    begin
                        hi_next = $signed({2'b00, mid_reg}) - (IDX_W+2)'(1);
                    end
                    else
                    begin
                        lo_next = $signed({2'b00, mid_reg}) + (IDX_W+2)'(1);
                    end
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            position_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
            position_reg <= position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        key_reg <= key_next;
        mid_reg <= mid_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;

endmodule

`default_nettype wire

/* sv/bsrch_chk.sv */
`default_nettype none

module bsrch_chk
    import bsrch_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             kind,
    input wire logic             done,
    input wire logic             found,
    input wire logic [IDX_W-1:0] position
);

    // a result frees the block in the same cycle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // a write item never yields a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_WRITE)) |=> !done)
        else $error("result after write item");

    // a search item always occupies the block
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_SEARCH)) |=> busy)
        else $error("search item did not start");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (position == '0))
        else $error("miss with nonzero position");

endmodule

bind sorted_table_binary_search bsrch_chk u_bsrch_chk (.*);

`default_nettype wire
